// ----- rtl/qdpm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpm_pkg: shared types and constants of the detent position mapper
// Field widths, beat layouts, register indexes, reset values and the
// quadrature step table.
// ----------------------------------------------------------------------------
package qdpm_pkg;

   localparam int unsigned DETENT_STEPS_DEF = 4;
   localparam int unsigned QUEUE_DEPTH_DEF  = 2;

   localparam int unsigned STEP_W    = 4;   // step accumulator, holds +/-4
   localparam int unsigned POS_W     = 16;
   localparam int unsigned VAL_W     = 32;
   localparam int unsigned MS_W      = 32;
   localparam int unsigned DEB_W     = 16;
   localparam int unsigned DIR_W     = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // request beat: enc_a, enc_b, button_pressed, now_ms
   localparam int unsigned REQ_A_BIT    = 0;
   localparam int unsigned REQ_B_BIT    = 1;
   localparam int unsigned REQ_BTN_BIT  = 2;
   localparam int unsigned REQ_MS_LSB   = 3;
   localparam int unsigned REQ_FIELDS_W = REQ_MS_LSB + MS_W;
   localparam int unsigned REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;

   // response beat: detent_dir, position, mapped_value, span_fault,
   // button_changed, button_state
   localparam int unsigned RSP_FIELDS_W = DIR_W + POS_W + VAL_W + 3;
   localparam int unsigned RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int unsigned RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   // mapping arithmetic
   localparam int unsigned SPAN_W    = POS_W + 1;          // signed span
   localparam int unsigned NXT_W     = POS_W + 2;          // position +/- 1, minus in_min
   localparam int unsigned MOD_DVD_W = POS_W + 1;          // |pos - in_min|
   localparam int unsigned PROD_W    = POS_W + VAL_W;      // |a| * |b|
   localparam int unsigned MAP_DVD_W = PROD_W + 1;         // 2|n| + |d|
   localparam int unsigned DVS_W     = POS_W + 1;          // 2|d|
   localparam int unsigned DIV_CNT_W = $clog2(MAP_DVD_W + 1);
   localparam int unsigned MOD_SHIFT = MAP_DVD_W - MOD_DVD_W;
   localparam int unsigned SUM_W     = MAP_DVD_W + 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEND_INCREMENT  = 3'd0,
      CSR_WRAP_AROUND     = 3'd1,
      CSR_IN_MIN          = 3'd2,
      CSR_IN_MAX          = 3'd3,
      CSR_OUT_MIN         = 3'd4,
      CSR_OUT_MAX         = 3'd5,
      CSR_INCREMENT_SCALE = 3'd6,
      CSR_DEBOUNCE_MS     = 3'd7
   } csr_index_type;

   localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
   localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
   localparam logic signed [DIR_W-1:0] DIR_BACK = 2'sb11;

   typedef struct packed {
      logic                    send_increment;
      logic                    wrap_around;
      logic signed [POS_W-1:0] in_min;
      logic signed [POS_W-1:0] in_max;
      logic signed [VAL_W-1:0] out_min;
      logic signed [VAL_W-1:0] out_max;
      logic signed [VAL_W-1:0] increment_scale;
      logic [DEB_W-1:0]        button_debounce_ms;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      send_increment:     1'b0,
      wrap_around:        1'b0,
      in_min:             16'sd0,
      in_max:             16'sd100,
      out_min:            32'sd0,
      out_max:            32'sd65536,
      increment_scale:    32'sd65536,
      button_debounce_ms: 16'd20
   };

   // one classified poll, handed from front to back
   typedef struct packed {
      logic signed [DIR_W-1:0] dir;
      logic                    changed;
      logic                    stable;
   } job_type;

   // Gray-code step, index is {previous AB, current AB}
   function automatic logic signed [DIR_W-1:0] gray_step(input logic [3:0] idx);
      logic signed [DIR_W-1:0] st;
      unique case (idx)
         4'd2, 4'd4, 4'd11, 4'd13: st = DIR_FWD;
         4'd1, 4'd7, 4'd8, 4'd14:  st = DIR_BACK;
         default:                  st = DIR_NONE;
      endcase
      return st;
   endfunction

endpackage : qdpm_pkg
`default_nettype wire

// ----- rtl/qdpm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpm_front: poll intake
// Takes one request beat per cycle while the queue has room, counts
// quadrature steps into detents and debounces the button.
// ----------------------------------------------------------------------------
module qdpm_front #(
   parameter int unsigned DETENT_STEPS = qdpm_pkg::DETENT_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [qdpm_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [qdpm_pkg::DEB_W-1:0]          debounce_ms,
   input  logic                                q_full,
   output logic                                q_push,
   output qdpm_pkg::job_type                   q_job
);
   import qdpm_pkg::*;

   localparam logic signed [STEP_W-1:0] D_POS = STEP_W'(DETENT_STEPS);
   localparam logic signed [STEP_W-1:0] D_NEG = -D_POS;

   logic [1:0]               prev_ab_ff, prev_ab_in;
   logic                     primed_ff, primed_in;
   logic signed [STEP_W-1:0] step_sum_ff, step_sum_in;
   logic                     cand_ff, cand_in;
   logic                     stable_ff, stable_in;
   logic [MS_W-1:0]          since_ff, since_in;

   logic                     accept;
   logic [1:0]               cur_ab;
   logic                     sample;
   logic [MS_W-1:0]          now_ms;
   logic signed [DIR_W-1:0]  step;
   logic signed [STEP_W-1:0] sum;
   logic signed [DIR_W-1:0]  dir;
   logic [MS_W-1:0]          held;
   logic                     fire;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;

   assign cur_ab = {req_tdata[REQ_A_BIT], req_tdata[REQ_B_BIT]};
   assign sample = req_tdata[REQ_BTN_BIT];
   assign now_ms = req_tdata[REQ_MS_LSB +: MS_W];

   always_comb begin
      step = primed_ff ? gray_step({prev_ab_ff, cur_ab}) : DIR_NONE;
      sum  = step_sum_ff + {{(STEP_W-DIR_W){step[DIR_W-1]}}, step};
      if (sum >= D_POS) begin
         dir         = DIR_FWD;
         step_sum_in = '0;
      end else if (sum <= D_NEG) begin
         dir         = DIR_BACK;
         step_sum_in = '0;
      end else begin
         dir         = DIR_NONE;
         step_sum_in = sum;
      end
      prev_ab_in = cur_ab;
      primed_in  = 1'b1;

      // a differing sample restarts the hold timer
      cand_in   = sample;
      since_in  = (sample != cand_ff) ? now_ms : since_ff;
      held      = now_ms - since_in;
      fire      = (stable_ff != sample) && (held >= MS_W'(debounce_ms));
      stable_in = fire ? sample : stable_ff;
   end

   assign q_push        = accept;
   assign q_job.dir     = dir;
   assign q_job.changed = fire;
   assign q_job.stable  = stable_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ab_ff  <= '0;
         primed_ff   <= 1'b0;
         step_sum_ff <= '0;
         cand_ff     <= 1'b0;
         stable_ff   <= 1'b0;
         since_ff    <= '0;
      end else if (accept) begin
         prev_ab_ff  <= prev_ab_in;
         primed_ff   <= primed_in;
         step_sum_ff <= step_sum_in;
         cand_ff     <= cand_in;
         stable_ff   <= stable_in;
         since_ff    <= since_in;
      end
   end

endmodule : qdpm_front
`default_nettype wire

// ----- rtl/qdpm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpm_queue: job queue
// Small register queue between the poll intake and the mapping back end.
// ----------------------------------------------------------------------------
module qdpm_queue #(
   parameter int unsigned DEPTH = qdpm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qdpm_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output qdpm_pkg::job_type pop_job,
   output logic              empty
);
   import qdpm_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule : qdpm_queue
`default_nettype wire

// ----- rtl/qdpm_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpm_divider: restoring divider
// Unsigned, one quotient bit per cycle. The dividend comes MSB-aligned and
// the step count says how many of its top bits take part.
// ----------------------------------------------------------------------------
module qdpm_divider #(
   parameter int unsigned DVD_W = qdpm_pkg::MAP_DVD_W,
   parameter int unsigned DVS_W = qdpm_pkg::DVS_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [DVD_W-1:0]                 dividend,
   input  logic [DVS_W-1:0]                 divisor,
   input  logic [$clog2(DVD_W+1)-1:0]       steps,
   output logic                             busy,
   output logic                             done,
   output logic [DVD_W-1:0]                 quotient,
   output logic [DVS_W-1:0]                 remainder
);
   localparam int unsigned CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DVS_W+1:0] trial;
   logic [DVS_W:0]   shifted;

   always_comb begin
      shifted = {rem_ff, quo_ff[DVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      if (trial[DVS_W+1]) begin
         rem_in = shifted[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], 1'b0};
      end else begin
         rem_in = trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule : qdpm_divider
`default_nettype wire

// ----- rtl/qdpm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdpm_back: detent execution
// Owns the absolute position. Steps, wraps or clamps it, maps it into the
// output range through a multiply and a shared serial divider, or sends
// the clamped increment, and holds the result in the response register.
// ----------------------------------------------------------------------------
module qdpm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  qdpm_pkg::cfg_type                cfg,
   input  logic                             pos_load,
   input  logic                             q_empty,
   output logic                             q_pop,
   input  qdpm_pkg::job_type                q_job,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [qdpm_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import qdpm_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_EVAL  = 8'b0000_0010,
      ST_MOD   = 8'b0000_0100,
      ST_MAP   = 8'b0000_1000,
      ST_MUL   = 8'b0001_0000,
      ST_DIVGO = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   logic signed [VAL_W-1:0] res_val_ff, res_val_in;
   logic                    res_fault_ff, res_fault_in;
   logic                    diff_neg_ff, diff_neg_in;
   logic [POS_W-1:0]        mag_a_ff, mag_a_in;
   logic [VAL_W-1:0]        mag_b_ff, mag_b_in;
   logic                    neg_ff, neg_in;
   logic [PROD_W-1:0]       prod_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // span and position arithmetic
   logic signed [SPAN_W-1:0] span, span_abs;
   logic                     span_zero, span_neg, span_pos;
   logic [POS_W-1:0]         span_mag;
   logic signed [NXT_W-1:0]  pos_step, in_min_x, in_max_x, diff, diff_abs;
   logic signed [POS_W-1:0]  clamp_pos;
   logic [POS_W-1:0]         wrap_off;

   // increment mode
   logic signed [VAL_W:0]    scale_x, omin_x, omax_x, inc_val, lo_x, hi_x, inc_clamped;

   // mapping
   logic signed [SPAN_W-1:0] a_val, a_abs;
   logic signed [VAL_W:0]    b_val, b_abs;
   logic [MAP_DVD_W:0]       q_signed;
   logic [SUM_W-1:0]         map_sum;
   logic [SUM_W-VAL_W:0]     map_top;
   logic signed [VAL_W-1:0]  map_sat;

   // divider
   logic                     div_start;
   logic [MAP_DVD_W-1:0]     div_dividend;
   logic [DVS_W-1:0]         div_divisor;
   logic [DIV_CNT_W-1:0]     div_steps;
   logic                     div_busy, div_done;
   logic [MAP_DVD_W-1:0]     div_quo;
   logic [DVS_W-1:0]         div_rem;

   qdpm_divider #(
      .DVD_W (MAP_DVD_W),
      .DVS_W (DVS_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      span      = {cfg.in_max[POS_W-1], cfg.in_max} - {cfg.in_min[POS_W-1], cfg.in_min};
      span_zero = (span == '0);
      span_neg  = span[SPAN_W-1];
      span_pos  = !span_zero && !span_neg;
      span_abs  = span_neg ? -span : span;
      span_mag  = span_abs[POS_W-1:0];

      in_min_x  = {{(NXT_W-POS_W){cfg.in_min[POS_W-1]}}, cfg.in_min};
      in_max_x  = {{(NXT_W-POS_W){cfg.in_max[POS_W-1]}}, cfg.in_max};
      pos_step  = {{(NXT_W-POS_W){pos_ff[POS_W-1]}}, pos_ff}
                + {{(NXT_W-DIR_W){job_ff.dir[DIR_W-1]}}, job_ff.dir};
      diff      = pos_step - in_min_x;
      diff_abs  = diff[NXT_W-1] ? -diff : diff;

      if (pos_step < in_min_x) begin
         clamp_pos = cfg.in_min;
      end else if (pos_step > in_max_x) begin
         clamp_pos = cfg.in_max;
      end else begin
         clamp_pos = pos_step[POS_W-1:0];
      end

      // negative offsets fold back from the top of the range
      if (diff_neg_ff && (div_rem[POS_W-1:0] != '0)) begin
         wrap_off = span_mag - div_rem[POS_W-1:0];
      end else begin
         wrap_off = div_rem[POS_W-1:0];
      end

      scale_x = {cfg.increment_scale[VAL_W-1], cfg.increment_scale};
      omin_x  = {cfg.out_min[VAL_W-1], cfg.out_min};
      omax_x  = {cfg.out_max[VAL_W-1], cfg.out_max};
      inc_val = (job_ff.dir == DIR_FWD) ? scale_x : -scale_x;
      lo_x    = (omin_x < omax_x) ? omin_x : omax_x;
      hi_x    = (omin_x < omax_x) ? omax_x : omin_x;
      if (inc_val < lo_x) begin
         inc_clamped = lo_x;
      end else if (inc_val > hi_x) begin
         inc_clamped = hi_x;
      end else begin
         inc_clamped = inc_val;
      end

      a_val = {pos_ff[POS_W-1], pos_ff} - {cfg.in_min[POS_W-1], cfg.in_min};
      a_abs = a_val[SPAN_W-1] ? -a_val : a_val;
      b_val = omax_x - omin_x;
      b_abs = b_val[VAL_W] ? -b_val : b_val;

      // out_min plus the signed rounded quotient, saturated
      q_signed = neg_ff ? -{1'b0, div_quo} : {1'b0, div_quo};
      map_sum  = {{(SUM_W-VAL_W){cfg.out_min[VAL_W-1]}}, cfg.out_min}
               + {q_signed[MAP_DVD_W], q_signed};
      map_top  = map_sum[SUM_W-1:VAL_W-1];
      if ((&map_top) || !(|map_top)) begin
         map_sat = map_sum[VAL_W-1:0];
      end else if (map_sum[SUM_W-1]) begin
         map_sat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         map_sat = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      res_val_in   = res_val_ff;
      res_fault_in = res_fault_ff;
      diff_neg_in  = diff_neg_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_in       = neg_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = {diff_abs[MOD_DVD_W-1:0], {MOD_SHIFT{1'b0}}};
      div_divisor  = {1'b0, span_mag};
      div_steps    = DIV_CNT_W'(MOD_DVD_W);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               job_in   = q_job;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            res_fault_in = 1'b0;
            if (job_ff.dir == DIR_NONE) begin
               res_val_in = '0;
               state_in   = ST_DONE;
            end else if (cfg.send_increment) begin
               res_val_in = inc_clamped[VAL_W-1:0];
               state_in   = ST_DONE;
            end else if (cfg.wrap_around && span_pos) begin
               diff_neg_in = diff[NXT_W-1];
               div_start   = 1'b1;
               state_in    = ST_MOD;
            end else begin
               pos_in   = clamp_pos;
               state_in = ST_MAP;
            end
         end
         ST_MOD: begin
            if (div_done) begin
               pos_in   = cfg.in_min + wrap_off;
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            if (span_zero) begin
               res_fault_in = 1'b1;
               res_val_in   = cfg.out_min;
               state_in     = ST_DONE;
            end else begin
               mag_a_in = a_abs[POS_W-1:0];
               mag_b_in = b_abs[VAL_W-1:0];
               neg_in   = a_val[SPAN_W-1] ^ b_val[VAL_W] ^ span_neg;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_DIVGO;
         end
         ST_DIVGO: begin
            // round half away from zero: (2|n| + |d|) / (2|d|)
            div_start    = 1'b1;
            div_dividend = {prod_ff, 1'b0} + MAP_DVD_W'(span_mag);
            div_divisor  = {span_mag, 1'b0};
            div_steps    = DIV_CNT_W'(MAP_DVD_W);
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               res_val_in = map_sat;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_W{1'b0}}, job_ff.stable, job_ff.changed,
                               res_fault_ff, res_val_ff, pos_ff, job_ff.dir};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // in_min write reloads the position; the user must write it only while idle (not enforced)
      if (pos_load) begin
         pos_in = cfg.in_min;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      res_val_ff  <= res_val_in;
      diff_neg_ff <= diff_neg_in;
      mag_a_ff    <= mag_a_in;
      mag_b_ff    <= mag_b_in;
      neg_ff      <= neg_in;
      prod_ff     <= PROD_W'(mag_a_ff * mag_b_ff);
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= CFG_RESET.in_min;
         res_fault_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         res_fault_ff <= res_fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider started while busy");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MOD || state_ff == ST_DIV))
      else $error("divider finished outside a waiting state");

   a_fault_abs_detent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && res_fault_ff) |-> (job_ff.dir != DIR_NONE && !cfg.send_increment))
      else $error("span fault without an absolute-mode detent");

endmodule : qdpm_back
`default_nettype wire

// ----- rtl/quadrature_detent_position_mapper.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_detent_position_mapper: rotary encoder detent mapper
// Turns encoder polls into detents, a bounded position and a Q16.16 value,
// with a debounced push button.
// ----------------------------------------------------------------------------
// Every request beat is one poll (A/B levels, raw button level, millisecond
// timestamp) and yields exactly one response beat, in order. The intake
// decodes the Gray-code step, counts DETENT_STEPS steps into a detent and
// debounces the button; it takes one beat per clock while its job queue
// (QUEUE_DEPTH entries) has room. The back end owns the absolute position
// and produces the value. A poll with no detent or in increment mode goes
// through the idle, eval and done states; an absolute-mode detent also goes
// through the multiply and the 49-step restoring divider that does the
// rounded linear mapping, and when wrapping the same divider first takes
// the position modulo the span (17 steps). The response register frees the
// back end to start the next job while a result waits. The user must write
// registers on the csr port only while the block is idle; the block does
// not enforce this. A write of in_min also reloads the position through
// pos_load. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module quadrature_detent_position_mapper #(
   parameter int unsigned DETENT_STEPS = qdpm_pkg::DETENT_STEPS_DEF,  // 1..4
   parameter int unsigned QUEUE_DEPTH  = qdpm_pkg::QUEUE_DEPTH_DEF    // 2 or more
) (
   input  logic                             clock,
   input  logic                             reset,
   // poll beat
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [0] enc_a, [1] enc_b, [2] button_pressed, [34:3] now_ms, rest zero
   input  logic [qdpm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // result beat
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [1:0] detent_dir, [17:2] position, [49:18] mapped_value,
   // [50] span_fault, [51] button_changed, [52] button_state, rest zero
   output logic [qdpm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [qdpm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [qdpm_pkg::VAL_W-1:0]       csr_data
);
   import qdpm_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    pos_load_ff, pos_load_in;
   logic    csr_write;

   logic    q_push, q_full, q_pop, q_empty;
   job_type push_job, pop_job;

   // register file; csr_ready is always high and every write lands in cfg_ff
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;

   always_comb begin
      cfg_in      = cfg_ff;
      pos_load_in = 1'b0;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEND_INCREMENT:  cfg_in.send_increment     = csr_data[0];
            CSR_WRAP_AROUND:     cfg_in.wrap_around        = csr_data[0];
            CSR_IN_MIN: begin
               cfg_in.in_min = csr_data[POS_W-1:0];
               pos_load_in   = 1'b1;
            end
            CSR_IN_MAX:          cfg_in.in_max             = csr_data[POS_W-1:0];
            CSR_OUT_MIN:         cfg_in.out_min            = csr_data;
            CSR_OUT_MAX:         cfg_in.out_max            = csr_data;
            CSR_INCREMENT_SCALE: cfg_in.increment_scale    = csr_data;
            CSR_DEBOUNCE_MS:     cfg_in.button_debounce_ms = csr_data[DEB_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         pos_load_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         pos_load_ff <= pos_load_in;
      end
   end

   qdpm_front #(
      .DETENT_STEPS (DETENT_STEPS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .debounce_ms (cfg_ff.button_debounce_ms),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   qdpm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .empty    (q_empty)
   );

   qdpm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pos_load   (pos_load_ff),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .q_job      (pop_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule : quadrature_detent_position_mapper
`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the quadrature detent position mapper
// Drives encoder polls and register writes on random handshake timing and
// checks every result beat against an in-bench model of the detent counter,
// position tracker, linear map and button debouncer, or a scripted result.
// ----------------------------------------------------------------------------
module testbench;
   import qdpm_pkg::*;

   localparam int     DETENTS         = DETENT_STEPS_DEF;
   localparam int     RANDOM_PHASES   = 12;
   localparam int     POLLS_PER_PHASE = 92;
   localparam int     TAIL_CYCLES     = 120;      // run-out after the final drain
   localparam int     RUN_LIMIT       = 1000000;
   localparam longint VAL_TOP         = 64'sd2147483647;
   localparam longint VAL_BOTTOM      = -64'sd2147483648;

   // one result beat, same field order as rsp_tdata from the bottom bit up
   typedef struct packed {
      logic signed [DIR_W-1:0] dir;
      logic signed [POS_W-1:0] position;
      logic signed [VAL_W-1:0] value;
      logic                    fault;
      logic                    changed;
      logic                    pressed;
   } poll_result_type;

   // directed stimulus: either a register write or a poll, the latter with
   // an optional hand-written result
   typedef struct packed {
      logic            is_write;
      csr_index_type   reg_index;
      logic [31:0]     wdata;
      logic [1:0]      ab;
      logic            btn;
      logic [31:0]     now;
      logic            typed;
      poll_result_type want;
   } script_row_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index  = '0;
   logic [VAL_W-1:0]       csr_data   = '0;

   quadrature_detent_position_mapper uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Gray-code step per {previous AB, current AB}
   int gray_delta [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
   // next AB level one quarter turn forward / backward
   logic [1:0] cw_next  [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
   logic [1:0] ccw_next [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

   // shadow of the register file
   bit          incr_mode    = CFG_RESET.send_increment;
   bit          wrap_mode    = CFG_RESET.wrap_around;
   shortint     pos_lo       = CFG_RESET.in_min;
   shortint     pos_hi       = CFG_RESET.in_max;
   int          val_lo       = CFG_RESET.out_min;
   int          val_hi       = CFG_RESET.out_max;
   int          detent_scale = CFG_RESET.increment_scale;
   logic [31:0] hold_ms      = 32'(CFG_RESET.button_debounce_ms);

   // shadow of the tracking state
   logic [1:0]  last_ab    = 2'd0;
   bit          ab_seen    = 1'b0;
   int          step_total = 0;
   shortint     track_pos  = CFG_RESET.in_min;
   logic        btn_cand   = 1'b0;
   logic        btn_level  = 1'b0;
   logic [31:0] cand_time  = '0;

   poll_result_type due_results [$];
   script_row_type  opening_script [$];

   int req_gap_max   = 6;
   int rsp_stall_max = 6;
   int hold_left     = 0;
   int cycle_count   = 0;
   int mismatches    = 0;
   int polls_sent    = 0;
   int detents_seen  = 0;
   int faults_seen   = 0;
   int changes_seen  = 0;
   poll_result_type seen_result, due_result;
   bit bad_beat;

   // Advance the shadow state by one poll and return the beat it must give.
   function automatic poll_result_type predict_poll(input logic [1:0] ab, input logic btn,
                                                    input logic [31:0] now);
      poll_result_type r;
      int dir;
      longint lo, hi, span, pos, rem, num, den, value;
      r = '0;
      dir = 0;
      value = 0;
      // the very first sample only seeds the previous level
      if (ab_seen)
         step_total += gray_delta[{last_ab, ab}];
      ab_seen = 1'b1;
      last_ab = ab;
      if (step_total >= DETENTS) begin
         step_total = 0;
         dir = 1;
      end else if (step_total <= -DETENTS) begin
         step_total = 0;
         dir = -1;
      end

      if (dir != 0 && incr_mode) begin
         // clamp to the output range, whichever way round it is
         lo = (val_lo < val_hi) ? val_lo : val_hi;
         hi = (val_lo < val_hi) ? val_hi : val_lo;
         value = dir * longint'(detent_scale);
         if (value < lo) value = lo;
         if (value > hi) value = hi;
      end else if (dir != 0) begin
         span = longint'(pos_hi) - longint'(pos_lo);
         pos = longint'(track_pos) + dir;
         if (wrap_mode && span > 0) begin
            rem = (pos - pos_lo) % span;
            if (rem < 0) rem += span;
            pos = pos_lo + rem;
         end else if (pos < pos_lo) begin
            pos = pos_lo;
         end else if (pos > pos_hi) begin
            pos = pos_hi;
         end
         track_pos = shortint'(pos);
         if (span == 0) begin
            r.fault = 1'b1;
            value = val_lo;
         end else begin
            // exact linear map, halves rounded away from zero
            num = (pos - pos_lo) * (longint'(val_hi) - longint'(val_lo));
            den = span;
            if (den < 0) begin
               num = -num;
               den = -den;
            end
            if (num >= 0) value = (2 * num + den) / (2 * den);
            else value = -((-2 * num + den) / (2 * den));
            value += val_lo;
            if (value > VAL_TOP) value = VAL_TOP;
            if (value < VAL_BOTTOM) value = VAL_BOTTOM;
         end
      end

      // debounce: a new level restarts the timer, accepted after hold_ms
      if (btn != btn_cand) begin
         btn_cand = btn;
         cand_time = now;
      end
      if (btn_level != btn_cand && (now - cand_time) >= hold_ms) begin
         btn_level = btn_cand;
         r.changed = 1'b1;
      end

      r.dir = (dir > 0) ? DIR_FWD : ((dir < 0) ? DIR_BACK : DIR_NONE);
      r.position = track_pos;
      r.value = value[31:0];
      r.pressed = btn_level;
      return r;
   endfunction

   task automatic script_poll(input logic [1:0] ab, input logic btn, input logic [31:0] now);
      script_row_type row;
      row = '0;
      row.ab = ab;
      row.btn = btn;
      row.now = now;
      opening_script.push_back(row);
   endtask

   // hand-written result for the poll just added
   task automatic script_want(input logic signed [DIR_W-1:0] dir, input shortint pos,
                              input logic [31:0] value, input logic fault,
                              input logic changed, input logic pressed);
      poll_result_type w;
      w = {dir, pos, value, fault, changed, pressed};
      opening_script[opening_script.size() - 1].typed = 1'b1;
      opening_script[opening_script.size() - 1].want = w;
   endtask

   task automatic script_write(input csr_index_type idx, input logic [31:0] data);
      script_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.reg_index = idx;
      row.wdata = data;
      opening_script.push_back(row);
   endtask

   // One register write. csr_valid is left high; the caller drops it once the
   // batch is done so that it never toggles twice in one step.
   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SEND_INCREMENT:  incr_mode = data[0];
         CSR_WRAP_AROUND:     wrap_mode = data[0];
         CSR_IN_MIN: begin
            pos_lo = shortint'(data[15:0]);
            track_pos = pos_lo;              // a new lower bound reloads the position
         end
         CSR_IN_MAX:          pos_hi = shortint'(data[15:0]);
         CSR_OUT_MIN:         val_lo = int'(data);
         CSR_OUT_MAX:         val_hi = int'(data);
         CSR_INCREMENT_SCALE: detent_scale = int'(data);
         CSR_DEBOUNCE_MS:     hold_ms = {16'h0000, data[15:0]};
         default: ;
      endcase
   endtask

   // One poll beat; the expected result is queued at the accepting edge.
   task automatic send_poll(input logic [1:0] ab, input logic btn, input logic [31:0] now,
                            input logic typed, input poll_result_type want);
      poll_result_type predicted;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - REQ_FIELDS_W){1'b0}}, now, btn, ab[0], ab[1]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_poll(ab, btn, now);
      if (typed) predicted = want;
      due_results.push_back(predicted);
      polls_sent++;
      if (predicted.dir != DIR_NONE) detents_seen++;
      if (predicted.fault) faults_seen++;
      if (predicted.changed) changes_seen++;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off new polls until every queued result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   // result side: check each beat, then stall for a random number of cycles
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_result = {rsp_tdata[1:0], rsp_tdata[17:2], rsp_tdata[49:18],
                        rsp_tdata[50], rsp_tdata[51], rsp_tdata[52]};
         if (due_results.size() == 0) begin
            $error("result beat with no poll outstanding: %h", rsp_tdata);
            mismatches++;
         end else begin
            due_result = due_results.pop_front();
            bad_beat = 1'b0;
            if (seen_result.dir !== due_result.dir) begin
               $error("detent_dir: expected %0d, got %0d", due_result.dir, seen_result.dir);
               bad_beat = 1'b1;
            end
            if (seen_result.position !== due_result.position) begin
               $error("position: expected %0d, got %0d",
                      due_result.position, seen_result.position);
               bad_beat = 1'b1;
            end
            if (seen_result.value !== due_result.value) begin
               $error("mapped_value: expected %0d, got %0d",
                      due_result.value, seen_result.value);
               bad_beat = 1'b1;
            end
            if (seen_result.fault !== due_result.fault) begin
               $error("span_fault: expected %0b, got %0b", due_result.fault, seen_result.fault);
               bad_beat = 1'b1;
            end
            if (seen_result.changed !== due_result.changed) begin
               $error("button_changed: expected %0b, got %0b",
                      due_result.changed, seen_result.changed);
               bad_beat = 1'b1;
            end
            if (seen_result.pressed !== due_result.pressed) begin
               $error("button_state: expected %0b, got %0b",
                      due_result.pressed, seen_result.pressed);
               bad_beat = 1'b1;
            end
            if (bad_beat) mismatches++;
         end
         hold_left = $urandom_range(0, rsp_stall_max);
      end else if (hold_left > 0) begin
         hold_left--;
      end
      rsp_tready <= (hold_left == 0);
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // watchdog
   initial begin
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("run stopped at the cycle limit with %0d results outstanding",
               due_results.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      script_row_type  row;
      poll_result_type none;
      logic [1:0]      ab;
      logic            btn;
      logic [31:0]     now;
      logic [31:0]     lo_out, hi_out, scale;
      shortint         lo, hi;
      int              pick, run_dir;

      none = '0;

      // --- directed part, reset register values ---
      // first poll after reset only seeds the previous AB level
      script_poll(2'd0, 1'b0, 32'd0);
      script_want(DIR_NONE, 0, 32'd0, 1'b0, 1'b0, 1'b0);
      // one full detent forward, then one back
      script_poll(2'd2, 1'b0, 32'd1);
      script_poll(2'd3, 1'b0, 32'd2);
      script_poll(2'd1, 1'b0, 32'd3);
      script_poll(2'd0, 1'b0, 32'd4);
      script_poll(2'd1, 1'b0, 32'd5);
      script_poll(2'd3, 1'b0, 32'd6);
      script_poll(2'd2, 1'b0, 32'd7);
      script_poll(2'd0, 1'b0, 32'd8);
      // illegal jump 00 -> 11 counts nothing; button held 19 then 20 ms
      script_poll(2'd3, 1'b1, 32'd100);
      script_poll(2'd3, 1'b1, 32'd119);
      script_poll(2'd3, 1'b1, 32'd120);
      script_want(DIR_NONE, 0, 32'd0, 1'b0, 1'b1, 1'b1);
      // release across the timestamp wrap
      script_poll(2'd3, 1'b0, 32'hFFFF_FFFF);
      script_poll(2'd3, 1'b0, 32'h0000_0013);
      // zero span: position pinned at in_min, value is out_min, fault set
      script_write(CSR_IN_MAX, 32'd0);
      script_poll(2'd1, 1'b0, 32'h14);
      script_poll(2'd0, 1'b0, 32'h15);
      script_poll(2'd2, 1'b0, 32'h16);
      script_poll(2'd3, 1'b0, 32'h17);
      script_want(DIR_FWD, 0, 32'd0, 1'b1, 1'b0, 1'b0);
      // increment mode at the extremes of the output range and scale
      script_write(CSR_SEND_INCREMENT, 32'd1);
      script_write(CSR_OUT_MIN, 32'h8000_0000);
      script_write(CSR_OUT_MAX, 32'h7FFF_FFFF);
      script_write(CSR_INCREMENT_SCALE, 32'h7FFF_FFFF);
      script_poll(2'd1, 1'b1, 32'h18);
      script_poll(2'd0, 1'b1, 32'h19);
      script_poll(2'd2, 1'b1, 32'h1A);
      script_poll(2'd3, 1'b1, 32'h1B);
      script_want(DIR_FWD, 0, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_script[i]) begin
         row = opening_script[i];
         if (row.is_write) begin
            drain_results();
            write_reg(row.reg_index, row.wdata);
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            send_poll(row.ab, row.btn, row.now, row.typed, row.want);
         end
      end

      // --- random part: one register setting per phase ---
      ab = 2'd3;
      btn = 1'b1;
      run_dir = 1;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();

         // position range: full, top edge, bottom edge, zero span, reversed,
         // small random; each with wrap off and on
         case ((p / 2) % 6)
            0: begin lo = -32768; hi = 32767; end
            1: begin lo = 32764; hi = 32767; end
            2: begin lo = -32768; hi = -32765; end
            3: begin
               lo = shortint'(int'($urandom_range(0, 16)) - 8);
               hi = lo;
            end
            4: begin
               lo = shortint'($urandom_range(0, 6));
               hi = lo - shortint'($urandom_range(1, 4));
            end
            default: begin
               lo = shortint'(int'($urandom_range(0, 40)) - 20);
               hi = lo + shortint'($urandom_range(1, 12));
            end
         endcase
         case (p % 4)
            0: begin lo_out = 32'h8000_0000; hi_out = 32'h7FFF_FFFF; end
            1: begin lo_out = 32'h7FFF_FFFF; hi_out = 32'h8000_0000; end
            2: begin lo_out = $urandom; hi_out = $urandom; end
            default: begin
               lo_out = $urandom_range(0, 1 << 18) - (1 << 17);
               hi_out = lo_out + $urandom_range(0, 1 << 20);
            end
         endcase
         case (p % 3)
            0: scale = 32'h8000_0000;
            1: scale = 32'h7FFF_FFFF;
            default: scale = $urandom;
         endcase

         write_reg(CSR_SEND_INCREMENT, (p % 4 == 3) ? 32'd1 : 32'd0);
         write_reg(CSR_WRAP_AROUND, 32'(p % 2));
         write_reg(CSR_IN_MAX, {16'h0000, hi});
         write_reg(CSR_IN_MIN, {16'h0000, lo});
         write_reg(CSR_OUT_MIN, lo_out);
         write_reg(CSR_OUT_MAX, hi_out);
         write_reg(CSR_INCREMENT_SCALE, scale);
         case (p % 5)
            0: write_reg(CSR_DEBOUNCE_MS, 32'd0);
            1: write_reg(CSR_DEBOUNCE_MS, 32'd65535);
            default: write_reg(CSR_DEBOUNCE_MS, $urandom_range(1, 30));
         endcase
         csr_valid <= 1'b0;

         // some phases run back to back on one side or the other
         req_gap_max = (p % 3 == 1) ? 0 : 6;
         rsp_stall_max = (p % 4 == 2) ? 0 : 6;
         now = (p == 4) ? 32'hFFFF_FF00 : $urandom;

         // mostly runs of proper quarter turns, with reversals, holds and
         // the odd illegal jump mixed in
         for (int k = 0; k < POLLS_PER_PHASE; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) run_dir = -run_dir;
            if (pick < 78) ab = (run_dir > 0) ? cw_next[ab] : ccw_next[ab];
            else if (pick >= 90) ab = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 5) == 0) btn = ~btn;
            if ($urandom_range(0, 39) == 0) now += $urandom;
            else now += $urandom_range(0, 12);
            send_poll(ab, btn, now, 1'b0, none);
            if (k + 1 < POLLS_PER_PHASE && $urandom_range(0, 59) == 0) drain_results();
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d polls: %0d detents, %0d zero-span faults, %0d button changes,",
               polls_sent, detents_seen, faults_seen, changes_seen);
      $display("over %0d random register settings plus the directed cases.", RANDOM_PHASES);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/qdpm_pkg.sv
rtl/qdpm_front.sv
rtl/qdpm_queue.sv
rtl/qdpm_divider.sv
rtl/qdpm_back.sv
rtl/quadrature_detent_position_mapper.sv
sim/testbench.sv
